[rtl/sfd_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sfd_pkg: shared types and constants of the sensor frame deframer
// framing bytes, result kinds, parser phases and the result record
// ----------------------------------------------------------------------------
package sfd_pkg;

  localparam logic [7:0] HeaderFirst    = 8'hAA;
  localparam logic [7:0] HeaderSecond   = 8'h55;
  localparam logic [7:0] MinLengthReset = 8'd3;

  typedef enum logic [1:0] {
    PH_HUNT     = 2'd0,
    PH_LENGTH   = 2'd1,
    PH_PAYLOAD  = 2'd2,
    PH_CHECKSUM = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    KIND_PAYLOAD  = 2'd0,
    KIND_GOOD     = 2'd1,
    KIND_MISMATCH = 2'd2,
    KIND_SHORT    = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] byte_value;
    logic [7:0] sub_id;
    logic [7:0] sub_index;
    logic       packet_last;
  } result_t;

endpackage
`default_nettype wire

[rtl/sfd_parser.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sfd_parser: frame parser state and per-byte decision logic
// header hunt, length check, sub-packet tracking and xor checksum
// ----------------------------------------------------------------------------
module sfd_parser import sfd_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       step_i,
  input  wire logic [7:0] byte_i,
  input  wire logic       restart_i,
  input  wire logic [7:0] min_len_i,
  output logic            res_valid_o,
  output result_t         result_o
);

  phase_e     phase_q, phase_d;
  logic       hdr_seen_q, hdr_seen_d;
  logic [7:0] len_q, len_d;
  logic [7:0] count_q, count_d;
  logic [7:0] xor_q, xor_d;
  logic [7:0] sub_id_q, sub_id_d;
  logic [7:0] sub_len_q, sub_len_d;
  logic [7:0] sub_pos_q, sub_pos_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_HUNT;
      hdr_seen_q <= 1'b0;
      len_q      <= '0;
      count_q    <= '0;
      xor_q      <= '0;
      sub_id_q   <= '0;
      sub_len_q  <= '0;
      sub_pos_q  <= '0;
    end else if (step_i) begin
      phase_q    <= phase_d;
      hdr_seen_q <= hdr_seen_d;
      len_q      <= len_d;
      count_q    <= count_d;
      xor_q      <= xor_d;
      sub_id_q   <= sub_id_d;
      sub_len_q  <= sub_len_d;
      sub_pos_q  <= sub_pos_d;
    end
  end

  always_comb begin
    logic       last;
    logic [8:0] sub_end;
    phase_d     = phase_q;
    hdr_seen_d  = hdr_seen_q;
    len_d       = len_q;
    count_d     = count_q;
    xor_d       = xor_q;
    sub_id_d    = sub_id_q;
    sub_len_d   = sub_len_q;
    sub_pos_d   = sub_pos_q;
    res_valid_o = 1'b0;
    result_o    = '0;
    last        = ({1'b0, count_q} + 9'd1) == {1'b0, len_q};
    sub_end     = '0;

    if (restart_i) begin
      phase_d    = PH_HUNT;
      hdr_seen_d = 1'b0;
      len_d      = '0;
      count_d    = '0;
      xor_d      = '0;
      sub_id_d   = '0;
      sub_len_d  = '0;
      sub_pos_d  = '0;
    end else begin
      case (phase_q)
        PH_HUNT: begin
          if (hdr_seen_q && byte_i == HeaderSecond) begin
            hdr_seen_d = 1'b0;
            phase_d    = PH_LENGTH;
          end else begin
            hdr_seen_d = (byte_i == HeaderFirst);
          end
        end
        PH_LENGTH: begin
          if (byte_i < min_len_i) begin
            res_valid_o         = 1'b1;
            result_o.kind       = KIND_SHORT;
            result_o.byte_value = byte_i;
          end else begin
            len_d     = byte_i;
            count_d   = '0;
            sub_pos_d = '0;
            sub_id_d  = '0;
            sub_len_d = '0;
            xor_d     = xor_q ^ byte_i;
            phase_d   = (byte_i == 8'd0) ? PH_CHECKSUM : PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          // id byte opens a sub-packet, the next byte gives its data length
          if (sub_pos_q == 8'd0) begin
            sub_id_d = byte_i;
          end else if (sub_pos_q == 8'd1) begin
            sub_len_d = byte_i;
          end
          res_valid_o          = 1'b1;
          result_o.kind        = KIND_PAYLOAD;
          result_o.byte_value  = byte_i;
          result_o.sub_id      = sub_id_d;
          result_o.sub_index   = sub_pos_q;
          result_o.packet_last = last;
          sub_end = {1'b0, sub_len_d} + 9'd1;
          if (sub_pos_q != 8'd0 && {1'b0, sub_pos_q} == sub_end) begin
            sub_pos_d = '0;
          end else begin
            sub_pos_d = sub_pos_q + 8'd1;
          end
          xor_d   = xor_q ^ byte_i;
          count_d = count_q + 8'd1;
          if (last) begin
            phase_d   = PH_CHECKSUM;
            sub_pos_d = '0;
          end
        end
        PH_CHECKSUM: begin
          res_valid_o         = 1'b1;
          result_o.kind       = (byte_i == xor_q) ? KIND_GOOD : KIND_MISMATCH;
          result_o.byte_value = byte_i;
          phase_d    = PH_HUNT;
          hdr_seen_d = 1'b0;
          len_d      = '0;
          count_d    = '0;
          xor_d      = '0;
          sub_id_d   = '0;
          sub_len_d  = '0;
          sub_pos_d  = '0;
        end
        default: begin
          phase_d = PH_HUNT;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  // hunting only follows a clear, so the checksum and count are still empty
  a_hunt_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_HUNT |-> xor_q == 8'd0 && count_q == 8'd0)
    else $error("parser state not cleared while hunting");

  // payload phase always ends before the count reaches the length
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_PAYLOAD |-> count_q < len_q)
    else $error("payload count overran the length");

  // a restart always lands in header hunt
  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && restart_i |=> phase_q == PH_HUNT && !hdr_seen_q)
    else $error("restart did not return to header hunt");
`endif

endmodule
`default_nettype wire

[rtl/sensor_frame_deframer.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sensor_frame_deframer: byte-serial deframer for header/length/xor frames
// finds 0xAA 0x55 headers, tags payload bytes with sub-packet id and position,
// and reports checksum status
// ----------------------------------------------------------------------------
// The block takes one received byte per transaction on the slave stream and
// accepts a byte every clock cycle unless a byte that needs the result
// register waits on a stalled master side. A byte passes through an input
// register and the parser and lands in the result register. Bytes that give no
// result (header bytes, accepted length bytes, restarts) leave the input
// register even while a result waits to be taken, so a stalled master side
// holds back only bytes that need the result register. Each frame is
// 0xAA 0x55, a length byte, that many payload bytes, and an xor checksum over
// the length and payload bytes. Payload bytes come out as kind 0, tagged with
// the id of their sub-packet (id, length, data) and the position inside it;
// tlast marks the last payload byte of a frame. The checksum byte gives kind 1
// (good) or kind 2 (mismatch), and a length below the minimum gives kind 3,
// after which the next byte is read as a length again. Status results carry
// the received byte and zero id, position and tlast. tuser high on the slave
// side drops the byte and resets the parser; the minimum length register is
// kept. Write the minimum length only while the stream is idle.
// ----------------------------------------------------------------------------
module sensor_frame_deframer import sfd_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration: minimum accepted payload length
  input  wire logic        cfg_wr_en_i,
  input  wire logic [7:0]  cfg_wr_data_i,
  // slave stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  wire logic [0:0]  s_axis_tuser,   // [0] restart
  // master stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,   // [7:0] byte_value, [15:8] sub_id,
                                           // [23:16] sub_index
  output logic [1:0]       m_axis_tuser,   // [1:0] kind
  output logic             m_axis_tlast    // packet_last
);

  // configuration register
  logic [7:0] min_len_q;

  // input register
  logic       in_valid_q, in_valid_d;
  logic [7:0] in_byte_q;
  logic       in_restart_q;

  // result register
  logic       out_valid_q, out_valid_d;
  result_t    out_res_q;

  // parser
  logic       step;
  logic       res_valid;
  result_t    res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_len_q <= MinLengthReset;
    end else if (cfg_wr_en_i) begin
      min_len_q <= cfg_wr_data_i;
    end
  end

  // an item moves on when it needs no output slot or the slot is free
  assign step = in_valid_q && (!res_valid || !out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || step;

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_axis_tvalid && s_axis_tready) begin
      in_valid_d = 1'b1;
    end else if (step) begin
      in_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (step && res_valid) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers, loaded on transactions only
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q    <= s_axis_tdata;
      in_restart_q <= s_axis_tuser[0];
    end
    if (step && res_valid) begin
      out_res_q <= res;
    end
  end

  sfd_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .byte_i      (in_byte_q),
    .restart_i   (in_restart_q),
    .min_len_i   (min_len_q),
    .res_valid_o (res_valid),
    .result_o    (res)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_res_q.sub_index, out_res_q.sub_id, out_res_q.byte_value};
  assign m_axis_tuser  = out_res_q.kind;
  assign m_axis_tlast  = out_res_q.packet_last;

`ifndef NO_ASSERTIONS
  // status results carry no sub-packet tags
  a_status_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != KIND_PAYLOAD |->
      m_axis_tdata[23:8] == 16'd0 && !m_axis_tlast)
    else $error("status result with sub-packet tags");

  // a result is never dropped: a stalled result stays valid next cycle
  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !m_axis_tready |=> out_valid_q)
    else $error("stalled result lost");
`endif

endmodule
`default_nettype wire

[sim/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the sensor frame deframer
// a directed table walks the header, length, sub-packet, checksum and restart
// cases, then random frames run under several minimum lengths; every result
// transaction is matched against a hand-written result or an in-bench deframer model
// ----------------------------------------------------------------------------
module testbench;
  import sfd_pkg::*;

  localparam int unsigned PipeDrain  = 8;     // cycles for bytes still in flight
  localparam int unsigned HoldCycles = 60;    // long master-side hold-off
  localparam int unsigned StallLimit = 2000;  // cycles with no transaction at all

  // one line of the directed table: a byte, or a write of the minimum length
  typedef struct packed {
    bit         is_cfg;
    logic [7:0] data;
    logic       restart;
    bit         typed;    // want holds a hand-written result
    result_t    want;
  } step_row_t;

  localparam result_t NoResult = '0;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [7:0]  cfg_wr_data = 8'h00;
  logic        s_tvalid = 1'b0;
  logic [7:0]  s_tdata = 8'h00;
  logic        s_tuser = 1'b0;
  logic        m_tready = 1'b0;
  wire         s_axis_tready;
  wire         m_axis_tvalid;
  wire  [23:0] m_axis_tdata;
  wire  [1:0]  m_axis_tuser;
  wire         m_axis_tlast;

  // in-bench copy of the deframer state and its register
  phase_e      parse_phase;
  logic        saw_first_sync;
  logic [7:0]  frame_len;
  logic [7:0]  frame_count;
  logic [7:0]  frame_xor;
  logic [7:0]  seg_id;
  logic [7:0]  seg_len;
  logic [7:0]  seg_pos;
  logic [7:0]  min_len;

  result_t     pending_results[$];
  int unsigned items_sent = 0;
  int unsigned failures = 0;
  int unsigned quiet_cycles = 0;
  bit          hold_req = 1'b0;

  // directed part, run with the reset minimum of 3 until the register row
  step_row_t directed_rows [27] = '{
    '{1'b0, 8'hAA, 1'b0, 1'b0, NoResult},
    '{1'b0, 8'h55, 1'b0, 1'b0, NoResult},
    // lengths below the minimum are rejected and the next byte is a length again
    '{1'b0, 8'h02, 1'b0, 1'b1, '{KIND_SHORT, 8'h02, 8'h00, 8'h00, 1'b0}},
    '{1'b0, 8'h00, 1'b0, 1'b1, '{KIND_SHORT, 8'h00, 8'h00, 8'h00, 1'b0}},
    // length 4: sub-packet 0x10 with one data byte, then 0x20 cut off by the end
    '{1'b0, 8'h04, 1'b0, 1'b0, NoResult},
    '{1'b0, 8'h10, 1'b0, 1'b0, NoResult},
    '{1'b0, 8'h01, 1'b0, 1'b0, NoResult},
    '{1'b0, 8'hFF, 1'b0, 1'b0, NoResult},
    '{1'b0, 8'h20, 1'b0, 1'b0, NoResult},
    '{1'b0, 8'hCA, 1'b0, 1'b1, '{KIND_GOOD, 8'hCA, 8'h00, 8'h00, 1'b0}},
    // repeated first sync byte still gives a header
    '{1'b0, 8'hAA, 1'b0, 1'b0, NoResult},
    '{1'b0, 8'hAA, 1'b0, 1'b0, NoResult},
    '{1'b0, 8'h55, 1'b0, 1'b0, NoResult},
    // zero-length sub-packet ends right after its length byte, bad checksum
    '{1'b0, 8'h03, 1'b0, 1'b0, NoResult},
    '{1'b0, 8'h00, 1'b0, 1'b0, NoResult},
    '{1'b0, 8'h00, 1'b0, 1'b0, NoResult},
    '{1'b0, 8'hFF, 1'b0, 1'b0, NoResult},
    '{1'b0, 8'h00, 1'b0, 1'b1, '{KIND_MISMATCH, 8'h00, 8'h00, 8'h00, 1'b0}},
    // restart in the middle of a frame also clears the running xor
    '{1'b0, 8'hAA, 1'b0, 1'b0, NoResult},
    '{1'b0, 8'h55, 1'b0, 1'b0, NoResult},
    '{1'b0, 8'h05, 1'b0, 1'b0, NoResult},
    '{1'b0, 8'hAA, 1'b1, 1'b0, NoResult},
    // minimum of zero lets a zero length go straight to the checksum
    '{1'b1, 8'h00, 1'b0, 1'b0, NoResult},
    '{1'b0, 8'hAA, 1'b0, 1'b0, NoResult},
    '{1'b0, 8'h55, 1'b0, 1'b0, NoResult},
    '{1'b0, 8'h00, 1'b0, 1'b0, NoResult},
    '{1'b0, 8'h00, 1'b0, 1'b1, '{KIND_GOOD, 8'h00, 8'h00, 8'h00, 1'b0}}
  };

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  sensor_frame_deframer DUT (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_wr_en_i   (cfg_wr_en),
    .cfg_wr_data_i (cfg_wr_data),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  function automatic void clear_frame_state();
    parse_phase    = PH_HUNT;
    saw_first_sync = 1'b0;
    frame_len      = 8'h00;
    frame_count    = 8'h00;
    frame_xor      = 8'h00;
    seg_id         = 8'h00;
    seg_len        = 8'h00;
    seg_pos        = 8'h00;
  endfunction

  // advances the model by one byte; returns 1 when the byte gives a result
  function automatic bit deframe_byte(input logic [7:0] b, input logic rs,
                                      output result_t res);
    logic [7:0] pos;
    logic       last;
    res = '0;
    if (rs) begin
      clear_frame_state();
      return 1'b0;
    end
    case (parse_phase)
      PH_HUNT: begin
        if (saw_first_sync && b == HeaderSecond) begin
          saw_first_sync = 1'b0;
          parse_phase    = PH_LENGTH;
        end else begin
          // a broken header byte is looked at again as a first sync byte
          saw_first_sync = (b == HeaderFirst);
        end
        return 1'b0;
      end
      PH_LENGTH: begin
        if (b < min_len) begin
          res.kind       = KIND_SHORT;
          res.byte_value = b;
          return 1'b1;
        end
        frame_len   = b;
        frame_count = 8'h00;
        seg_pos     = 8'h00;
        seg_id      = 8'h00;
        seg_len     = 8'h00;
        frame_xor   = frame_xor ^ b;
        parse_phase = (b == 8'h00) ? PH_CHECKSUM : PH_PAYLOAD;
        return 1'b0;
      end
      PH_PAYLOAD: begin
        pos = seg_pos;
        if (pos == 8'd0) seg_id = b;
        else if (pos == 8'd1) seg_len = b;
        last = ({1'b0, frame_count} + 9'd1 == {1'b0, frame_len});
        res.kind        = KIND_PAYLOAD;
        res.byte_value  = b;
        res.sub_id      = seg_id;
        res.sub_index   = pos;
        res.packet_last = last;
        // the sub-packet closes after its last data byte, or after its length byte when it has no data
        if (pos >= 8'd1 && {1'b0, pos} == {1'b0, seg_len} + 9'd1) seg_pos = 8'h00;
        else seg_pos = pos + 8'd1;
        frame_xor   = frame_xor ^ b;
        frame_count = frame_count + 8'd1;
        if (last) begin
          parse_phase = PH_CHECKSUM;
          seg_pos     = 8'h00;
        end
        return 1'b1;
      end
      default: begin
        res.kind       = (b == frame_xor) ? KIND_GOOD : KIND_MISMATCH;
        res.byte_value = b;
        clear_frame_state();
        return 1'b1;
      end
    endcase
  endfunction

  // idle share in percent: sender 20 / receiver 47, then swapped, then none
  function automatic int unsigned idle_pct(bit receiver);
    if (items_sent < 300) return receiver ? 47 : 20;
    if (items_sent < 600) return receiver ? 20 : 47;
    return 0;
  endfunction

  // offers one byte, waits for its transaction and records what it must give
  task automatic send_byte(input logic [7:0] b, input logic rs,
                           input bit typed = 1'b0, input result_t want = '0);
    result_t res;
    if ($urandom_range(99) < idle_pct(1'b0)) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tuser  <= rs;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    if (deframe_byte(b, rs, res)) pending_results = {pending_results, (typed ? want : res)};
    items_sent++;
  endtask

  // register writes only with the stream drained
  task automatic set_min_length(input logic [7:0] v);
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (PipeDrain) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    min_len = v;
  endtask

  // one frame with random content, sometimes with noise, a broken header,
  // rejected lengths, a bad checksum or a restart somewhere inside
  task automatic send_random_frame();
    logic [7:0]  frame_q[$];
    logic [7:0]  len;
    logic [7:0]  b;
    logic [7:0]  xsum;
    int unsigned roll;
    int unsigned hi;
    int unsigned cut;
    int unsigned pos;
    int unsigned slen;
    roll = $urandom_range(99);
    if (roll < 12) begin
      repeat ($urandom_range(3, 1)) frame_q = {frame_q, 8'($urandom)};
    end else if (roll < 20) begin
      frame_q = {frame_q, HeaderFirst};
      frame_q = {frame_q, 8'($urandom)};
    end
    frame_q = {frame_q, HeaderFirst};
    frame_q = {frame_q, HeaderSecond};
    if (min_len != 8'h00 && $urandom_range(99) < 10) begin
      repeat ($urandom_range(2, 1)) frame_q = {frame_q, 8'($urandom_range(min_len - 1))};
    end
    // mostly short payloads, a few longer ones
    hi = int'(min_len) + (($urandom_range(99) < 5) ? 40 : 10);
    if (hi > 255) hi = 255;
    len = 8'($urandom_range(hi, min_len));
    frame_q = {frame_q, len};
    xsum = len;
    pos  = 0;
    slen = 0;
    repeat (len) begin
      // sub-packet lengths are mostly small so that several fit in a frame
      if (pos == 1) b = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(4));
      else b = 8'($urandom);
      if (pos == 1) slen = 32'(b);
      pos  = (pos >= 1 && pos == slen + 1) ? 0 : pos + 1;
      xsum = xsum ^ b;
      frame_q = {frame_q, b};
    end
    frame_q = {frame_q,
               (($urandom_range(99) < 80) ? xsum : xsum ^ 8'($urandom_range(255, 1)))};
    cut = ($urandom_range(99) < 6) ? $urandom_range(frame_q.size() - 1) : frame_q.size();
    foreach (frame_q[k]) begin
      if (k == cut) send_byte(8'($urandom), 1'b1);
      send_byte(frame_q[k], 1'b0);
    end
  endtask

  // master side: random stalls, plus one long hold-off that backs up the block
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        m_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
      end
      m_tready <= ($urandom_range(99) >= idle_pct(1'b1));
    end
  end

  // result check and watchdog
  always @(posedge clk) begin : check_results
    result_t want;
    if (rst_n && m_axis_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result transaction: tdata %h tuser %0d tlast %0d",
               m_axis_tdata, m_axis_tuser, m_axis_tlast);
        failures++;
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tuser !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, m_axis_tuser);
          failures++;
        end
        if (m_axis_tdata[7:0] !== want.byte_value) begin
          $error("byte_value: expected %h, got %h", want.byte_value, m_axis_tdata[7:0]);
          failures++;
        end
        if (m_axis_tdata[15:8] !== want.sub_id) begin
          $error("sub_id: expected %h, got %h", want.sub_id, m_axis_tdata[15:8]);
          failures++;
        end
        if (m_axis_tdata[23:16] !== want.sub_index) begin
          $error("sub_index: expected %0d, got %0d", want.sub_index, m_axis_tdata[23:16]);
          failures++;
        end
        if (m_axis_tlast !== want.packet_last) begin
          $error("packet_last: expected %0d, got %0d", want.packet_last, m_axis_tlast);
          failures++;
        end
      end
    end
    if ((s_tvalid && s_axis_tready) || (m_axis_tvalid && m_tready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= StallLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // main sequence
  initial begin
    logic [7:0]  phase_mins [4];
    int unsigned phase_end;
    clear_frame_state();
    min_len = MinLengthReset;
    // directed table ends with the minimum at zero, random frames go on at it;
    // then the widest minimum (one long frame), the reset value and a random one
    phase_mins = '{8'h00, 8'hFF, MinLengthReset, 8'($urandom_range(254, 1))};
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_cfg) set_min_length(directed_rows[i].data);
      else send_byte(directed_rows[i].data, directed_rows[i].restart,
                     directed_rows[i].typed, directed_rows[i].want);
    end
    hold_req = 1'b1;
    for (int p = 0; p < 4; p++) begin
      if (p > 0) set_min_length(phase_mins[p]);
      phase_end = items_sent + ((phase_mins[p] == 8'hFF) ? 1 : 200);
      while (items_sent < phase_end) send_random_frame();
    end
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (PipeDrain) @(posedge clk);
    if (failures == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
